### rtl/dnse_pkg.sv
// dnse_pkg: shared types and constants of the DNS name wire-format encoder.
// Used by dnse_front, dnse_cmd_fifo, dnse_back, the top level and the testbench; no dependencies.
package dnse_pkg;

	localparam int LABEL_CAPACITY_DEF = 62;   // label store size, 1..63
	localparam int CNT_W              = 6;    // label byte count
	localparam int CMD_FIFO_DEPTH     = 2;    // front-to-back command queue

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// One command per input item that causes output.
	typedef struct packed {
		logic             do_label;   // emit length byte and stored bytes
		logic             do_term;    // emit zero terminator afterwards
		logic [CNT_W-1:0] len;        // stored bytes of the label
		logic             ovf;        // label was truncated
		logic             bank;       // label store bank holding the bytes
	} cmd_t;

	// Label store write, front to back.
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [CNT_W-1:0] addr;
		logic [7:0]       data;
	} store_wr_t;

	// Bank release, back to front: the bank's bytes have all been read.
	typedef struct packed {
		logic en;
		logic bank;
	} bank_rel_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LEN,
		BK_DATA,
		BK_TERM
	} back_state_t;

endpackage

### rtl/dnse_in_if.sv
// dnse_in_if: input character channel, valid/ready with character payload.
// No dependencies.
interface dnse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_text;

	modport source (output valid, output char_byte, output end_of_text, input ready);
	modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

### rtl/dnse_out_if.sv
// dnse_out_if: output byte channel, valid/ready with wire-format byte and flags.
// No dependencies.
interface dnse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_length;
	logic       name_end;
	logic       overflow;
	logic       last;

	modport source (output valid, output out_byte, output is_length, output name_end,
		output overflow, output last, input ready);
	modport sink   (input valid, input out_byte, input is_length, input name_end,
		input overflow, input last, output ready);
endinterface

### rtl/dnse_front.sv
// dnse_front: accepts characters, tracks label/name state, writes the label
// store and queues one command per item. Depends on dnse_pkg, dnse_in_if.
module dnse_front import dnse_pkg::*; #(
	parameter int LABEL_CAPACITY = LABEL_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dnse_in_if.sink     in_ch,
	input  logic        cmd_full,
	output logic        cmd_push,
	output cmd_t        cmd_data,
	output store_wr_t   store_wr,
	input  bank_rel_t   bank_rel
);

	logic [CNT_W-1:0] cnt_q;
	logic             in_name_q;
	logic             trunc_q;
	logic             wbank_q;
	logic [1:0]       busy_q;

	logic             accept;
	logic             is_sp, is_dot, is_ch, cnt_full;
	logic [CNT_W-1:0] cnt1;
	logic             trunc1, in1;
	logic             lab_a, lab_b, do_term;

	assign in_ch.ready = !cmd_full && !busy_q[wbank_q];
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		is_sp    = (in_ch.char_byte == CH_SPACE);
		is_dot   = (in_ch.char_byte == CH_DOT);
		is_ch    = !is_sp && !is_dot;
		cnt_full = (cnt_q == CNT_W'(LABEL_CAPACITY));

		// state after the character itself
		cnt1   = is_ch ? (cnt_full ? cnt_q : cnt_q + CNT_W'(1)) : '0;
		trunc1 = is_ch && (trunc_q || cnt_full);
		in1    = !is_sp;

		// label closed by the character, or by end of text afterwards
		lab_a   = is_dot || (is_sp && in_name_q && (cnt_q != '0));
		lab_b   = in_ch.end_of_text && in1 && (cnt1 != '0);
		do_term = (is_sp && in_name_q) || (in_ch.end_of_text && in1);

		cmd_data.do_label = lab_a || lab_b;
		cmd_data.do_term  = do_term;
		cmd_data.len      = lab_a ? cnt_q : cnt1;
		cmd_data.ovf      = lab_a ? trunc_q : trunc1;
		cmd_data.bank     = wbank_q;
		cmd_push          = accept && (lab_a || lab_b || do_term);

		store_wr.en   = accept && is_ch && !cnt_full;
		store_wr.bank = wbank_q;
		store_wr.addr = cnt_q;
		store_wr.data = in_ch.char_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			in_name_q <= 1'b0;
			trunc_q   <= 1'b0;
			wbank_q   <= 1'b0;
			busy_q    <= '0;
		end else begin
			if (bank_rel.en) begin
				busy_q[bank_rel.bank] <= 1'b0;
			end
			if (accept) begin
				if (in_ch.end_of_text || lab_a) begin
					cnt_q   <= '0;
					trunc_q <= 1'b0;
				end else begin
					cnt_q   <= cnt1;
					trunc_q <= trunc1;
				end
				in_name_q <= in1 && !in_ch.end_of_text;
				// a queued label owns its bank until the back end has read it
				if (cmd_push && cmd_data.do_label) begin
					busy_q[wbank_q] <= 1'b1;
					wbank_q         <= !wbank_q;
				end
			end
		end
	end

endmodule

### rtl/dnse_cmd_fifo.sv
// dnse_cmd_fifo: short command queue between front and back.
// Depends on dnse_pkg.
module dnse_cmd_fifo import dnse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
	localparam int CNT_WF = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t              mem_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_WF-1:0] count_q;

	assign full  = (count_q == CNT_WF'(CMD_FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_WF'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_WF'(1);
			end
		end
	end

endmodule

### rtl/dnse_back.sv
// dnse_back: label store (two banks) and the byte sequencer that turns
// commands into wire-format bytes. Depends on dnse_pkg, dnse_out_if.
module dnse_back import dnse_pkg::*; #(
	parameter int LABEL_CAPACITY = LABEL_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  store_wr_t  store_wr,
	input  logic       cmd_empty,
	input  cmd_t       cmd_head,
	output logic       cmd_pop,
	output bank_rel_t  bank_rel,
	dnse_out_if.source out_ch
);

	localparam int ADDR_W    = (LABEL_CAPACITY > 1) ? $clog2(LABEL_CAPACITY) : 1;
	localparam int MEM_DEPTH = 2 * (1 << ADDR_W);

	logic [7:0]        store_mem [MEM_DEPTH];
	logic [7:0]        rd_data_q;
	logic              rd_en;
	logic [ADDR_W:0]   rd_addr;

	back_state_t       state_q, state_d;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  remain_q, remain_d;
	logic [ADDR_W-1:0] rd_idx_q, rd_idx_d;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              is_length_q, name_end_q, overflow_q, last_q;

	logic              slot_free, ld;
	logic [7:0]        ld_byte;
	logic              ld_isl, ld_end, ld_ovf, ld_last;

	// label store: front writes one bank while this side reads the other
	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			store_mem[{store_wr.bank, store_wr.addr[ADDR_W-1:0]}] <= store_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	assign slot_free = !out_valid_q || out_ch.ready;

	always_comb begin
		state_d  = state_q;
		remain_d = remain_q;
		rd_idx_d = rd_idx_q;
		cmd_pop  = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		bank_rel = '0;
		ld       = 1'b0;
		ld_byte  = '0;
		ld_isl   = 1'b0;
		ld_end   = 1'b0;
		ld_ovf   = 1'b0;
		ld_last  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					state_d = cmd_head.do_label ? BK_LEN : BK_TERM;
				end
			end
			BK_LEN: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_byte = 8'(cmd_q.len);
					ld_isl  = 1'b1;
					ld_ovf  = cmd_q.ovf;
					ld_last = !cmd_q.do_term && (cmd_q.len == '0);
					if (cmd_q.len == '0) begin
						bank_rel.en   = 1'b1;
						bank_rel.bank = cmd_q.bank;
						state_d       = cmd_q.do_term ? BK_TERM : BK_IDLE;
					end else begin
						// fetch the first byte while the length goes out
						rd_en    = 1'b1;
						rd_addr  = {cmd_q.bank, ADDR_W'(0)};
						rd_idx_d = ADDR_W'(1);
						remain_d = cmd_q.len;
						state_d  = BK_DATA;
					end
				end
			end
			BK_DATA: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_byte = rd_data_q;
					ld_last = !cmd_q.do_term && (remain_q == CNT_W'(1));
					if (remain_q == CNT_W'(1)) begin
						bank_rel.en   = 1'b1;
						bank_rel.bank = cmd_q.bank;
						state_d       = cmd_q.do_term ? BK_TERM : BK_IDLE;
					end else begin
						rd_en    = 1'b1;
						rd_addr  = {cmd_q.bank, rd_idx_q};
						rd_idx_d = rd_idx_q + ADDR_W'(1);
						remain_d = remain_q - CNT_W'(1);
					end
				end
			end
			BK_TERM: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_isl  = 1'b1;
					ld_end  = 1'b1;
					ld_last = 1'b1;
					state_d = BK_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		remain_q <= remain_d;
		rd_idx_q <= rd_idx_d;
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
		if (ld) begin
			out_byte_q  <= ld_byte;
			is_length_q <= ld_isl;
			name_end_q  <= ld_end;
			overflow_q  <= ld_ovf;
			last_q      <= ld_last;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_byte  = out_byte_q;
	assign out_ch.is_length = is_length_q;
	assign out_ch.name_end  = name_end_q;
	assign out_ch.overflow  = overflow_q;
	assign out_ch.last      = last_q;

endmodule

### rtl/dns_name_to_wire_encoder.sv
// dns_name_to_wire_encoder: top level, front end, command queue and back end.
// Depends on dnse_pkg, dnse_in_if, dnse_out_if, dnse_front, dnse_cmd_fifo, dnse_back.
//
// Usage:
//   in_ch carries one text character per transfer (char_byte, end_of_text).
//   out_ch carries one wire-format byte per transfer: a label length byte
//   (is_length=1, overflow when the label was cut to LABEL_CAPACITY bytes),
//   a label byte, or a zero terminator (is_length=1, name_end=1). last marks
//   the final byte caused by one input character.
//   The front takes one character per cycle while in_ch.ready is high and writes
//   label bytes into one of two label store banks; a dot, a name-ending space
//   or end of text queues a command (two entries deep). The back end pops a
//   command, then sends one byte per cycle while out_ch does not stall:
//   length, label bytes, terminator.
//   in_ch.ready drops when the command queue is full or when both label
//   banks still hold labels waiting to be sent.
//   Reset clears the name and label state, the queue and the output valid;
//   the label store is not cleared, only bytes written for a label are read.
//   When out_ch stalls, the output register holds its byte, the back end
//   waits, and the front keeps taking characters until the queue or the
//   label banks fill.
module dns_name_to_wire_encoder import dnse_pkg::*; #(
	parameter int LABEL_CAPACITY = LABEL_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dnse_in_if.sink    in_ch,
	dnse_out_if.source out_ch
);

	logic      cmd_full, cmd_push, cmd_pop, cmd_empty;
	cmd_t      cmd_data, cmd_head;
	store_wr_t store_wr;
	bank_rel_t bank_rel;

	// character classification, label counting, store writes
	dnse_front #(
		.LABEL_CAPACITY(LABEL_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd_data (cmd_data),
		.store_wr (store_wr),
		.bank_rel (bank_rel)
	);

	// decouples the character rate from the output burst rate
	dnse_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_data),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.head      (cmd_head),
		.empty     (cmd_empty)
	);

	// label store and output byte sequencer
	dnse_back #(
		.LABEL_CAPACITY(LABEL_CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.store_wr  (store_wr),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.bank_rel  (bank_rel),
		.out_ch    (out_ch)
	);

endmodule

### rtl/dnse_checker.sv
// dnse_checker: port-level assertions on the encoder output, bound to the top.
// Depends on dns_name_to_wire_encoder and its interfaces.
module dnse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       is_length,
	input logic       name_end,
	input logic       overflow,
	input logic       last
);

	// a stalled output byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_length)
			&& $stable(name_end) && $stable(overflow) && $stable(last))
		else $error("output changed while stalled");

	// a terminator is a zero length byte and always ends the item's results
	a_term_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_end |-> is_length && (out_byte == 8'h00) && !overflow && last)
		else $error("malformed terminator");

	// overflow only on a real length byte
	a_ovf_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> is_length && !name_end)
		else $error("overflow on non-length byte");

	// label bytes carry no flags
	a_data_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_length |-> !overflow && !name_end)
		else $error("flags on label byte");

endmodule

bind dns_name_to_wire_encoder dnse_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.is_length (out_ch.is_length),
	.name_end  (out_ch.name_end),
	.overflow  (out_ch.overflow),
	.last      (out_ch.last)
);

### tb/dnse_checker.sv
`timescale 1ns / 1ps
// dnse_tb_checker: watches both channels of the DNS name encoder, predicts the
// wire bytes of each character transfer and compares them in order.
// Depends on dnse_pkg, dnse_in_if and dnse_out_if.
module dnse_tb_checker import dnse_pkg::*; #(
	parameter int CAPACITY = LABEL_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dnse_in_if   in_ch,
	dnse_out_if  out_ch,
	output int   fail_count,
	output int   pending,
	output int   bytes_checked,
	output int   labels_cut
);

	typedef struct {
		logic [7:0] val;
		logic       is_len;
		logic       term;
		logic       ovf;
		logic       last;
	} wire_byte_t;

	wire_byte_t       wire_bytes_due[$];
	logic [7:0]       lab_buf [CAPACITY];
	logic [CNT_W-1:0] lab_len;
	logic             name_open;
	logic             lab_cut;

	function void push_wire(input logic [7:0] val, input logic is_len, input logic term,
		input logic ovf);
		wire_byte_t wb;
		wb = '{val, is_len, term, ovf, 1'b0};
		wire_bytes_due.push_back(wb);
	endfunction

	function void flush_label();
		push_wire({2'b00, lab_len}, 1'b1, 1'b0, lab_cut);
		if (lab_cut)
			labels_cut++;
		for (int k = 0; k < lab_len; k++)
			push_wire(lab_buf[k], 1'b0, 1'b0, 1'b0);
		lab_len = '0;
		lab_cut = 1'b0;
	endfunction

	function void close_name();
		if (name_open) begin
			if (lab_len != 0)
				flush_label();
			push_wire(8'h00, 1'b1, 1'b1, 1'b0);
			name_open = 1'b0;
			lab_len   = '0;
			lab_cut   = 1'b0;
		end
	endfunction

	function void encode_char(input logic [7:0] c, input logic eot);
		int         first;
		wire_byte_t tail;
		first = wire_bytes_due.size();
		if (c == CH_SPACE) begin
			close_name();
		end else if (c == CH_DOT) begin
			name_open = 1'b1;
			flush_label();
		end else begin
			name_open = 1'b1;
			if (lab_len < CAPACITY) begin
				lab_buf[lab_len] = c;
				lab_len++;
			end else begin
				lab_cut = 1'b1;
			end
		end
		if (eot)
			close_name();
		if (wire_bytes_due.size() > first) begin
			tail      = wire_bytes_due.pop_back();
			tail.last = 1'b1;
			wire_bytes_due.push_back(tail);
		end
	endfunction

	function void report_field(input string field, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		$display("%0t: wire byte %0d %s expected %h got %h", $time, bytes_checked, field,
			exp_v, got_v);
		fail_count++;
	endfunction

	function void check_wire_byte();
		wire_byte_t got;
		wire_byte_t exp_b;
		got = '{out_ch.out_byte, out_ch.is_length, out_ch.name_end, out_ch.overflow,
			out_ch.last};
		bytes_checked++;
		if (wire_bytes_due.size() == 0) begin
			$display("%0t: unexpected wire byte %h (is_length %b name_end %b overflow %b last %b)",
				$time, got.val, got.is_len, got.term, got.ovf, got.last);
			fail_count++;
			return;
		end
		exp_b = wire_bytes_due.pop_front();
		if (got.val !== exp_b.val)
			report_field("out_byte", exp_b.val, got.val);
		if (got.is_len !== exp_b.is_len)
			report_field("is_length", {7'd0, exp_b.is_len}, {7'd0, got.is_len});
		if (got.term !== exp_b.term)
			report_field("name_end", {7'd0, exp_b.term}, {7'd0, got.term});
		if (got.ovf !== exp_b.ovf)
			report_field("overflow", {7'd0, exp_b.ovf}, {7'd0, got.ovf});
		if (got.last !== exp_b.last)
			report_field("last", {7'd0, exp_b.last}, {7'd0, got.last});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_bytes_due.delete();
			lab_len       = '0;
			name_open     = 1'b0;
			lab_cut       = 1'b0;
			fail_count    = 0;
			pending       = 0;
			bytes_checked = 0;
			labels_cut    = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				encode_char(in_ch.char_byte, in_ch.end_of_text);
			if (out_ch.valid && out_ch.ready)
				check_wire_byte();
			pending = wire_bytes_due.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for dns_name_to_wire_encoder; checking is done
// by dnse_tb_checker. Depends on dnse_pkg, dnse_in_if, dnse_out_if and the RTL.
module tb_top;
	import dnse_pkg::*;

	localparam int CAPACITY     = LABEL_CAPACITY_DEF;
	localparam int RANDOM_CHARS = 60;    // random transfers that can change state
	localparam int QUIET_TAIL   = 20;    // last random transfers with no idling
	localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
	localparam int DRAIN_LIMIT  = 5000;  // cycles allowed for the last bytes
	localparam int SETTLE       = 20;    // extra cycles after the last byte

	logic clk = 1'b0;
	logic arst_n;

	dnse_in_if  in_ch();
	dnse_out_if out_ch();

	int   fail_count;
	int   pending;
	int   bytes_checked;
	int   labels_cut;
	int   chars_sent;     // transfers not ignored by the block
	logic name_open_tb;   // mirrors whether a name is open, for the count above
	logic quiet;          // no idling on either side
	logic hold_req;       // asks the receiver for one long hold-off

	dns_name_to_wire_encoder #(.LABEL_CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	dnse_tb_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_checked (bytes_checked),
		.labels_cut    (labels_cut)
	);

	always #1 clk = ~clk;

	// Any byte except the two separators.
	function automatic logic [7:0] label_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_SPACE || b == CH_DOT);
		return b;
	endfunction

	// One character transfer. Driven at the falling edge, with an optional
	// idle burst first; ready is sampled at the rising edge. Returns at the
	// falling edge after the transfer, so the next call can keep valid high.
	task automatic send_char(input logic [7:0] c, input logic eot);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.char_byte   <= c;
		in_ch.end_of_text <= eot;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
		if (c != CH_SPACE || name_open_tb)
			chars_sent++;
		name_open_tb = (c != CH_SPACE) && !eot;
	endtask

	task automatic send_text(input string s, input logic eot_last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], eot_last && (i == s.len() - 1));
	endtask

	// Receiver: random stall bursts, one long hold-off on request, and a
	// steady ready once the quiet tail starts.
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [7:0] txt[$];
		int         start;
		int         n_lab;
		int         len;
		int         mode;
		int         r;

		in_ch.valid       = 1'b0;
		in_ch.char_byte   = 8'h00;
		in_ch.end_of_text = 1'b0;
		arst_n            = 1'b0;
		quiet             = 1'b0;
		hold_req          = 1'b0;
		chars_sent        = 0;
		name_open_tb      = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: leading and repeated spaces, a two-label name.
		send_text("  ab.c  ", 1'b0);
		// Empty labels at the start and in the middle, trailing dot.
		send_text("..x. ", 1'b0);
		// Zero byte and all-ones byte as label bytes; end of text on a label byte.
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_DOT, 1'b0);
		send_char(8'h7F, 1'b1);
		// End of text on a dot: the terminator alone follows.
		send_text("q.", 1'b1);
		// Text of spaces only gives nothing.
		send_text("   ", 1'b1);
		// End of text on the space that closes a name: one terminator only.
		send_text("z ", 1'b1);
		// A lone dot with end of text: zero length, then terminator.
		send_char(CH_DOT, 1'b1);

		// Full-size label and a truncated one while the receiver holds off,
		// so the label banks and the command queue fill and input stalls.
		hold_req = 1'b1;
		txt.delete();
		repeat (CAPACITY) txt.push_back(label_char());
		txt.push_back(CH_DOT);
		repeat (CAPACITY + 4) txt.push_back(label_char());
		txt.push_back(CH_SPACE);
		foreach (txt[i])
			send_char(txt[i], 1'b0);

		// Random: mostly well-formed names with random bytes, some noise.
		start = chars_sent;
		while (chars_sent - start < RANDOM_CHARS) begin
			quiet = (chars_sent - start >= RANDOM_CHARS - QUIET_TAIL);
			if ($urandom_range(0, 9) == 0) begin
				send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				txt.delete();
				n_lab = $urandom_range(1, 4);
				for (int li = 0; li < n_lab; li++) begin
					r = $urandom_range(0, 99);
					if (r < 5)
						len = 0;
					else if (r < 8)
						len = $urandom_range(CAPACITY - 3, CAPACITY + 3);
					else
						len = $urandom_range(1, 10);
					repeat (len) txt.push_back(label_char());
					if (li < n_lab - 1 || $urandom_range(0, 7) == 0)
						txt.push_back(CH_DOT);
				end
				// Name end: end of text on the last byte, on a space, or by spaces.
				mode = $urandom_range(0, 3);
				foreach (txt[i])
					send_char(txt[i], mode == 0 && i == txt.size() - 1);
				if (mode == 1)
					send_char(CH_SPACE, 1'b1);
				else if (mode >= 2)
					repeat ($urandom_range(1, 3)) send_char(CH_SPACE, 1'b0);
			end
		end
		in_ch.valid <= 1'b0;

		// Drain: wait for every predicted byte, then let the pipe settle.
		for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (pending != 0)
			$display("%0t: %0d predicted wire bytes never arrived", $time, pending);

		$display("Encoded %0d characters into %0d wire bytes, %0d labels truncated.",
			chars_sent, bytes_checked, labels_cut);
		$display("Covered empty and trailing labels, space runs, end of text and input stalls.");
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("%0t: timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
